// ===== hdl/assert_macros.svh =====
// Assertion macros for the dual-stack block.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// a must hold at every edge outside reset
`define SADS_ASSERT_ALWAYS(label, clk, rst_n, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a)) \
        else $error("always-true check failed");
// a implies b at the same edge
`define SADS_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");
// a implies b at the next edge
`define SADS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define SADS_ASSERT_ALWAYS(label, clk, rst_n, a)
`define SADS_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define SADS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

// ===== hdl/sads_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sads_pkg
// Types and constants shared by the dual-stack controller, datapath and top.
// ----------------------------------------------------------------------------
package sads_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W = 32;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_POP   = 1'b1;
    localparam logic SIDE_LOW  = 1'b0;
    localparam logic SIDE_HIGH = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                     command;
        logic                     which_stack;
        logic signed [WORD_W-1:0] push_word;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] pop_word;
        logic [1:0]               status;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch request, decide status and address
        logic execute;   // perform store access, update count
    } dp_ctrl_t;

    // datapath -> observers
    typedef struct packed {
        logic [CNT_W-1:0] low_count;
        logic [CNT_W-1:0] high_count;
    } dp_stat_t;

endpackage

// ===== hdl/sads_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sads_dp
// Datapath: word store, stack counts, address and status decode, result reg.
// ----------------------------------------------------------------------------
module sads_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  sads_pkg::dp_ctrl_t ctrl,
    input  sads_pkg::req_t     req,
    output sads_pkg::rsp_t     rsp,
    output sads_pkg::dp_stat_t stat
);

    localparam logic [sads_pkg::CNT_W-1:0] DEPTH_C = sads_pkg::CNT_W'(sads_pkg::DEPTH);

    logic [sads_pkg::WORD_W-1:0] store_mem [sads_pkg::DEPTH];

    logic [sads_pkg::CNT_W-1:0]  low_count_reg, low_count_next;
    logic [sads_pkg::CNT_W-1:0]  high_count_reg, high_count_next;

    logic                        pop_reg;
    logic                        high_reg;
    logic                        ok_reg;
    logic [1:0]                  status_reg;
    logic [sads_pkg::ADDR_W-1:0] addr_reg;
    logic [sads_pkg::WORD_W-1:0] word_reg;
    logic [sads_pkg::WORD_W-1:0] rd_reg;

    logic [sads_pkg::CNT_W:0]    used;
    logic [1:0]                  status_next;
    logic [sads_pkg::CNT_W-1:0]  addr_full;

    assign used = (sads_pkg::CNT_W+1)'(low_count_reg) + (sads_pkg::CNT_W+1)'(high_count_reg);

    // status and slot for the incoming request
    always_comb
    begin
        status_next = sads_pkg::ST_OK;
        addr_full   = low_count_reg;
        if (req.command == sads_pkg::CMD_PUSH)
        begin
            if (used >= (sads_pkg::CNT_W+1)'(sads_pkg::DEPTH))
                status_next = sads_pkg::ST_FULL;
            if (req.which_stack == sads_pkg::SIDE_HIGH)
                addr_full = DEPTH_C - high_count_reg - sads_pkg::CNT_W'(1);
            else
                addr_full = low_count_reg;
        end
        else
        begin
            if (req.which_stack == sads_pkg::SIDE_HIGH)
            begin
                if (high_count_reg == '0)
                    status_next = sads_pkg::ST_EMPTY;
                addr_full = DEPTH_C - high_count_reg;
            end
            else
            begin
                if (low_count_reg == '0)
                    status_next = sads_pkg::ST_EMPTY;
                addr_full = low_count_reg - sads_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            pop_reg    <= req.command;
            high_reg   <= req.which_stack;
            ok_reg     <= (status_next == sads_pkg::ST_OK);
            status_reg <= status_next;
            addr_reg   <= addr_full[sads_pkg::ADDR_W-1:0];
            word_reg   <= req.push_word;
        end
    end

    // store access
    always_ff @(posedge clk)
    begin
        if (ctrl.execute && ok_reg && pop_reg == sads_pkg::CMD_PUSH)
            store_mem[addr_reg] <= word_reg;
        if (ctrl.execute)
            rd_reg <= store_mem[addr_reg];
    end

    always_comb
    begin
        low_count_next  = low_count_reg;
        high_count_next = high_count_reg;
        if (ctrl.execute && ok_reg)
        begin
            if (high_reg == sads_pkg::SIDE_HIGH)
                high_count_next = (pop_reg == sads_pkg::CMD_POP)
                                ? high_count_reg - sads_pkg::CNT_W'(1)
                                : high_count_reg + sads_pkg::CNT_W'(1);
            else
                low_count_next  = (pop_reg == sads_pkg::CMD_POP)
                                ? low_count_reg - sads_pkg::CNT_W'(1)
                                : low_count_reg + sads_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_count_reg  <= '0;
            high_count_reg <= '0;
        end
        else
        begin
            low_count_reg  <= low_count_next;
            high_count_reg <= high_count_next;
        end
    end

    assign rsp.pop_word = (ok_reg && pop_reg == sads_pkg::CMD_POP) ? rd_reg : '0;
    assign rsp.status   = status_reg;

    assign stat.low_count  = low_count_reg;
    assign stat.high_count = high_count_reg;

endmodule

// ===== hdl/sads_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sads_ctrl
// Controller: sequences one word through capture, store access and response.
// ----------------------------------------------------------------------------
module sads_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sads_pkg::dp_ctrl_t ctrl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign req_stall    = (state_reg != S_IDLE);
    assign rsp_valid    = (state_reg == S_DONE);
    assign ctrl.capture = (state_reg == S_IDLE) && req_valid;
    assign ctrl.execute = (state_reg == S_EXEC);

endmodule

// ===== hdl/shared_array_dual_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_array_dual_stack
// Two LIFO stacks sharing one 16-word store, low stack up, high stack down.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req) carries one word: a push or
//   pop command, the stack it targets, and the word to push.
//   Response channel (rsp_valid / rsp_stall / rsp) returns exactly one word
//   per request: the popped word (zero unless a pop succeeded) and a status
//   of ok, stack empty (pop) or store full (push).
//   The response becomes valid once the request has passed the store-access
//   state into the response state. One request is handled at a time, set by
//   the controller's capture / store access / response sequence around the
//   single registered-read store port.
//   req_stall is high from acceptance until the response has been taken, so
//   one request is in flight at a time.
//   A stalled response holds its word until rsp_stall drops.
//   Reset empties both stacks (counts cleared); store contents are not
//   cleared, and a word read from an unwritten slot never reaches rsp.pop_word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shared_array_dual_stack
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  sads_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output sads_pkg::rsp_t rsp
);

    sads_pkg::dp_ctrl_t ctrl;
    sads_pkg::dp_stat_t stat;

    // sequencing
    sads_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctrl      (ctrl)
    );

    // store, counts and result
    sads_dp u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .req   (req),
        .rsp   (rsp),
        .stat  (stat)
    );

    // the two stacks never overlap
    `SADS_ASSERT_ALWAYS(a_no_overlap, clk, rst_n, ((sads_pkg::CNT_W+1)'(stat.low_count) + (sads_pkg::CNT_W+1)'(stat.high_count)) <= (sads_pkg::CNT_W+1)'(sads_pkg::DEPTH))
    // a request is never taken while a response is pending
    `SADS_ASSERT_IMPLIES(a_one_in_flight, clk, rst_n, req_valid && !req_stall, !rsp_valid)
    // failed operations return a zero word
    `SADS_ASSERT_IMPLIES(a_fail_zero, clk, rst_n, rsp_valid && rsp.status != sads_pkg::ST_OK, rsp.pop_word == '0)
    // the store-access step (execute) is followed by a valid response
    `SADS_ASSERT_NEXT(a_exec_to_done, clk, rst_n, ctrl.execute, rsp_valid)

endmodule
